// ===== hdl/plr_pkg.sv =====
// ----------------------------------------------------------------------------
// plr_pkg - shared types and constants of the lattice relaxation solver
// Sequencer states, item and register codes, saturation helper.
// ----------------------------------------------------------------------------
`default_nettype none
package plr_pkg;
  localparam int MAX_SITES = 64;
  localparam int SITE_W    = $clog2(MAX_SITES);
  localparam int SIZE_W    = SITE_W + 1;
  localparam int CFG_IDX_W = 3;

  typedef enum logic [1:0] {
    OP_LOAD_SRC = 2'd0,
    OP_LOAD_PHI = 2'd1,
    OP_RUN      = 2'd2,
    OP_NONE     = 2'd3
  } op_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_MODE  = 3'd0,
    REG_SWEEP = 3'd1,
    REG_SIZE  = 3'd2,
    REG_DIAG  = 3'd3,
    REG_INV   = 3'd4
  } reg_idx_t;

  typedef enum logic [3:0] {
    S_IDLE, S_RA, S_RB, S_RC, S_MUL, S_WR, S_CA, S_CB, S_RD, S_RM, S_RE
  } state_t;

  // clamp a wide signed value into 32-bit signed range
  function automatic logic [31:0] sat32(input logic signed [49:0] x);
    logic [31:0] r;
    if (x > 50'sd2147483647) r = 32'h7FFF_FFFF;
    else if (x < -50'sd2147483648) r = 32'h8000_0000;
    else r = x[31:0];
    return r;
  endfunction
endpackage
`default_nettype wire

// ===== hdl/plr_if.sv =====
// ----------------------------------------------------------------------------
// plr_if - handshake channels of the lattice relaxation solver
// Input item, result item and register write channels.
// ----------------------------------------------------------------------------
`default_nettype none
interface plr_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  op;
  logic [5:0]  site;
  logic [31:0] value;
  modport source (output valid, op, site, value, input ready);
  modport sink   (input valid, op, site, value, output ready);
endinterface

interface plr_out_if;
  logic        valid;
  logic        ready;
  logic [5:0]  out_site;
  logic [31:0] solution;
  logic [31:0] residue;
  logic        last;
  modport source (output valid, out_site, solution, residue, last, input ready);
  modport sink   (input valid, out_site, solution, residue, last, output ready);
endinterface

interface plr_cfg_if;
  logic        valid;
  logic        ready;
  logic [2:0]  index;
  logic [31:0] data;
  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface
`default_nettype wire

// ===== hdl/plr_ram.sv =====
// ----------------------------------------------------------------------------
// plr_ram - generic single-write, single-read RAM
// One write port, one read port with registered data.
// ----------------------------------------------------------------------------
`default_nettype none
module plr_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata <= mem[raddr];
  end
endmodule
`default_nettype wire

// ===== hdl/periodic_lattice_relaxation_solver.sv =====
// ----------------------------------------------------------------------------
// periodic_lattice_relaxation_solver - Jacobi / Gauss-Seidel on a 1D ring
// Per sweep each site in use passes RA, RB, RC, MUL and WR, plus CA and CB for
// the copy-back in Jacobi mode; then a residue pass takes each site through RA,
// RB, RC, RD, RM and RE. The pace is set by the single read port of the phi
// memory (three reads per site) and the registered multiply. One beat at a time.
// Reset (rst, synchronous) clears control and loads register defaults; the
// stores hold no reset value.
// ----------------------------------------------------------------------------
`default_nettype none
module periodic_lattice_relaxation_solver (
  input  wire logic clk,
  input  wire logic rst,
  plr_in_if.sink    in_ch,
  plr_out_if.source out_ch,
  plr_cfg_if.sink   cfg_ch
);
  import plr_pkg::*;

  // configuration registers
  logic        solver_mode;
  logic [15:0] sweep_count;
  logic [6:0]  lattice_size;
  logic [30:0] diag_term;
  logic [31:0] inv_diag;

  state_t state, state_next;

  logic [SITE_W-1:0] idx;     // current site
  logic [15:0]       sweep;   // sweeps done
  logic              resid;   // residue pass under way
  logic [SIZE_W-1:0] n_sites; // sites in use for this run

  logic [31:0] left, right, src_v, centre, mag;
  logic        neg;
  logic [63:0] prod;

  // output register
  logic              ov;
  logic [SITE_W-1:0] o_site;
  logic [31:0]       o_sol, o_res;
  logic              o_last;

  // memory ports
  logic              phi_we, src_we, scr_we;
  logic [SITE_W-1:0] phi_wa, phi_ra, src_wa, src_ra, scr_ra;
  logic [31:0]       phi_wd, src_wd, phi_rd, src_rd, scr_rd;

  plr_ram #(.WIDTH(32), .DEPTH(MAX_SITES)) u_phi (
    .clk(clk), .we(phi_we), .waddr(phi_wa), .wdata(phi_wd), .raddr(phi_ra), .rdata(phi_rd));
  plr_ram #(.WIDTH(32), .DEPTH(MAX_SITES)) u_src (
    .clk(clk), .we(src_we), .waddr(src_wa), .wdata(src_wd), .raddr(src_ra), .rdata(src_rd));
  plr_ram #(.WIDTH(32), .DEPTH(MAX_SITES)) u_scr (
    .clk(clk), .we(scr_we), .waddr(idx), .wdata(phi_wd), .raddr(scr_ra), .rdata(scr_rd));

  // neighbours on the ring
  logic              at_end;
  logic [SITE_W-1:0] lf, rt, last_idx;
  assign last_idx = SITE_W'(n_sites - SIZE_W'(1));
  assign at_end   = (idx == last_idx);
  assign lf       = (idx == '0) ? last_idx : idx - SITE_W'(1);
  assign rt       = at_end ? '0 : idx + SITE_W'(1);

  logic in_fire, run_fire, out_free, last_sweep;
  assign in_ch.ready = (state == S_IDLE);
  assign in_fire     = in_ch.valid && in_ch.ready;
  assign run_fire    = in_fire && (op_t'(in_ch.op) == OP_RUN);
  assign out_free    = !ov || out_ch.ready;
  assign last_sweep  = (sweep + 16'd1 == sweep_count);

  // relaxation sum and its rounded quotient
  logic signed [49:0] sum_w;
  logic [31:0]        sum_s, q, relaxed;
  assign sum_w = $signed({{18{left[31]}}, left}) + $signed({{18{phi_rd[31]}}, phi_rd})
               - $signed({{18{src_v[31]}}, src_v});
  assign sum_s = sat32(sum_w);
  assign q     = prod[63:32];
  always_comb begin
    if (neg) relaxed = 32'd0 - q;
    else if (q[31]) relaxed = 32'h7FFF_FFFF;
    else relaxed = q;
  end

  // residue: source - (left + right - diag*phi)
  logic signed [49:0] dq, res_w;
  assign dq    = neg ? -$signed({3'b000, prod[62:16]}) : $signed({3'b000, prod[62:16]});
  assign res_w = $signed({{18{src_v[31]}}, src_v})
               - ($signed({{18{left[31]}}, left}) + $signed({{18{right[31]}}, right}) - dq);

  // memory port steering
  always_comb begin
    phi_we = 1'b0; phi_wa = idx; phi_wd = relaxed;
    src_we = 1'b0; src_wa = in_ch.site; src_wd = in_ch.value;
    scr_we = 1'b0;
    phi_ra = '0; src_ra = idx; scr_ra = idx;
    unique case (state)
      S_IDLE: begin
        phi_wa = in_ch.site; phi_wd = in_ch.value;
        phi_we = in_fire && (op_t'(in_ch.op) == OP_LOAD_PHI);
        src_we = in_fire && (op_t'(in_ch.op) == OP_LOAD_SRC);
      end
      S_RA: phi_ra = lf;
      S_RB: phi_ra = rt;
      S_RC: phi_ra = idx;
      S_WR: begin
        phi_we = solver_mode;
        scr_we = !solver_mode;
      end
      S_CB: begin
        phi_we = 1'b1;
        phi_wd = scr_rd;
      end
      default: ;
    endcase
  end

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: if (run_fire) state_next = S_RA;
      S_RA:   state_next = S_RB;
      S_RB:   state_next = S_RC;
      S_RC:   state_next = resid ? S_RD : S_MUL;
      S_MUL:  state_next = S_WR;
      S_WR:   state_next = (at_end && !solver_mode) ? S_CA : S_RA;
      S_CA:   state_next = S_CB;
      S_CB:   state_next = at_end ? S_RA : S_CA;
      S_RD:   state_next = S_RM;
      S_RM:   state_next = S_RE;
      S_RE:   if (out_free) state_next = at_end ? S_IDLE : S_RA;
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) state <= S_IDLE;
    else state <= state_next;
  end

  // configuration writes
  assign cfg_ch.ready = 1'b1;
  always_ff @(posedge clk) begin
    if (rst) begin
      solver_mode  <= 1'b0;
      sweep_count  <= 16'd50;
      lattice_size <= 7'd8;
      diag_term    <= 31'd147456;
      inv_diag     <= 32'd1908874354;
    end else if (cfg_ch.valid) begin
      unique case (cfg_ch.index)
        REG_MODE:  solver_mode  <= cfg_ch.data[0];
        REG_SWEEP: sweep_count  <= cfg_ch.data[15:0];
        REG_SIZE:  lattice_size <= cfg_ch.data[6:0];
        REG_DIAG:  diag_term    <= cfg_ch.data[30:0];
        REG_INV:   inv_diag     <= cfg_ch.data;
        default: ;
      endcase
    end
  end

  // sequencer counters
  always_ff @(posedge clk) begin
    if (rst) begin
      idx <= '0; sweep <= '0; resid <= 1'b0; n_sites <= SIZE_W'(2);
    end else begin
      unique case (state)
        S_IDLE: if (run_fire) begin
          idx   <= '0;
          sweep <= '0;
          resid <= (sweep_count == 16'd0);
          // clamp the ring size
          if (lattice_size < 7'd2) n_sites <= SIZE_W'(2);
          else if (lattice_size > 7'(MAX_SITES)) n_sites <= SIZE_W'(MAX_SITES);
          else n_sites <= SIZE_W'(lattice_size);
        end
        S_WR: begin
          if (!at_end) idx <= idx + SITE_W'(1);
          else begin
            idx <= '0;
            // Gauss-Seidel closes the sweep here; Jacobi after the copy
            if (solver_mode) begin
              sweep <= sweep + 16'd1;
              if (last_sweep) resid <= 1'b1;
            end
          end
        end
        S_CB: begin
          if (!at_end) idx <= idx + SITE_W'(1);
          else begin
            idx   <= '0;
            sweep <= sweep + 16'd1;
            if (last_sweep) resid <= 1'b1;
          end
        end
        S_RE: if (out_free) idx <= at_end ? '0 : idx + SITE_W'(1);
        default: ;
      endcase
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    unique case (state)
      S_RB: begin
        left  <= phi_rd;
        src_v <= src_rd;
      end
      S_RC: begin
        right <= phi_rd;
        neg   <= sum_s[31];
        mag   <= sum_s[31] ? 32'd0 - sum_s : sum_s;
      end
      S_MUL: prod <= {32'd0, mag} * {32'd0, inv_diag} + 64'h8000_0000;
      S_RD: begin
        centre <= phi_rd;
        neg    <= phi_rd[31];
        mag    <= phi_rd[31] ? 32'd0 - phi_rd : phi_rd;
      end
      S_RM: prod <= {32'd0, mag} * {33'd0, diag_term} + 64'h8000;
      default: ;
    endcase
  end

  // result register: load in S_RE, drop on the taken beat
  always_ff @(posedge clk) begin
    if (rst) ov <= 1'b0;
    else if (state == S_RE && out_free) ov <= 1'b1;
    else if (out_ch.ready) ov <= 1'b0;
  end

  always_ff @(posedge clk) begin
    if (state == S_RE && out_free) begin
      o_site <= idx;
      o_sol  <= centre;
      o_res  <= sat32(res_w);
      o_last <= at_end;
    end
  end

  assign out_ch.valid    = ov;
  assign out_ch.out_site = o_site;
  assign out_ch.solution = o_sol;
  assign out_ch.residue  = o_res;
  assign out_ch.last     = o_last;

  // a run beat always leaves idle
  a_run_starts: assert property (@(posedge clk) disable iff (rst)
    run_fire |=> state != S_IDLE) else $error("run beat did not start the sequencer");
  // the final result of a run is loaded as the sequencer returns to idle
  a_last_idle: assert property (@(posedge clk) disable iff (rst)
    (state == S_RE && out_free && at_end) |=> (state == S_IDLE && out_ch.valid && out_ch.last))
    else $error("last result not loaded at run end");
  // scratch is written in Jacobi mode only
  a_scr_mode: assert property (@(posedge clk) disable iff (rst)
    scr_we |-> !solver_mode) else $error("scratch write in Gauss-Seidel mode");
  // no new result while one is stalled
  a_no_overrun: assert property (@(posedge clk) disable iff (rst)
    (state == S_RE && ov && !out_ch.ready) |=> state == S_RE) else $error("result overrun");
endmodule
`default_nettype wire
